/* rtl/core/mrm_pkg.sv */
`default_nettype none

package mrm_pkg;

  localparam int unsigned WindowDef   = 5;
  localparam int unsigned RankDef     = 2;
  localparam int unsigned ChannelsDef = 4;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned ChannelW = 2;

  typedef logic signed [SampleW-1:0]  sample_t;
  typedef logic        [ChannelW-1:0] channel_t;

endpackage

`default_nettype wire

/* rtl/core/mrm_rank_sel.sv */
`default_nettype none

module mrm_rank_sel #(
  parameter int unsigned WINDOW = mrm_pkg::WindowDef,
  parameter int unsigned RANK   = mrm_pkg::RankDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [WINDOW-1:0][mrm_pkg::SampleW-1:0] win_i,
  input  wire logic                                   ack_i,
  output logic                                        found_o,
  output mrm_pkg::sample_t                            value_o
);

  import mrm_pkg::*;

  localparam int unsigned PosW = $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(WINDOW + 1);

  logic [WINDOW-1:0][SampleW-1:0] win_q;
  logic [PosW-1:0]                cand_q;
  logic                           busy_q;
  sample_t                        key;
  logic [CntW-1:0]                cnt;

  assign key = sample_t'(win_q[cand_q]);

  // rank of the candidate; ties ordered by position
  always_comb begin
    cnt = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (($signed(win_q[j]) < key) ||
          (($signed(win_q[j]) == key) && (PosW'(j) < cand_q))) begin
        cnt = cnt + 1'b1;
      end
    end
  end

  assign found_o = busy_q && (cnt == CntW'(RANK));
  assign value_o = key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cand_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cand_q <= '0;
    end else if (ack_i) begin
      busy_q <= 1'b0;
    end else if (busy_q && !found_o) begin
      cand_q <= cand_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      win_q <= win_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/multichannel_running_median.sv */
// An accepted sample's channel row is read, then written back with the sample at the
// channel's write position, then the rank scan checks one candidate entry per cycle
// in position order until the selected entry is found; the median is loaded once the
// output slot is free. A channel number of CHANNELS or above skips the window and
// its sample is passed to the output. A new item is accepted only while idle. Reset:
// all windows read as zero and all write positions are zero; no clearing pass.
`default_nettype none

module multichannel_running_median_core #(
  parameter int unsigned WINDOW      = mrm_pkg::WindowDef,
  parameter int unsigned MEDIAN_RANK = mrm_pkg::RankDef,
  parameter int unsigned CHANNELS    = mrm_pkg::ChannelsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mrm_pkg::channel_t channel_i,
  input  wire mrm_pkg::sample_t  sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mrm_pkg::sample_t       median_o
);

  import mrm_pkg::*;

  localparam int unsigned RankEff = (MEDIAN_RANK > WINDOW - 1) ? WINDOW - 1 : MEDIAN_RANK;
  localparam int unsigned PosW    = $clog2(WINDOW);
  localparam int unsigned ChIdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMod  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StByp  = 2'd3;

  typedef logic [WINDOW-1:0][SampleW-1:0] row_t;

  logic [1:0]         state_q, state_d;
  logic [ChIdxW-1:0]  ch_q;
  sample_t            sample_q;
  logic [PosW-1:0]    pos_q [CHANNELS];
  logic [CHANNELS-1:0] row_vld_q;
  row_t               mem_q [CHANNELS];
  row_t               rd_row_q;
  row_t               new_row;
  logic               out_valid_q;
  sample_t            median_q;

  logic               in_acc;
  logic               in_range;
  logic [ChIdxW-1:0]  ch_idx;
  logic               slot_free;
  logic               wr_en;
  logic               found;
  sample_t            rank_val;
  logic               scan_ack;
  logic               out_load;
  sample_t            out_val;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign in_range    = (int'(channel_i) < CHANNELS);
  assign ch_idx      = ChIdxW'(channel_i);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign wr_en       = (state_q == StMod);
  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  always_comb begin
    new_row = row_vld_q[ch_q] ? rd_row_q : '0;
    new_row[pos_q[ch_q]] = sample_q;
  end

  always_comb begin
    state_d  = state_q;
    scan_ack = 1'b0;
    out_load = 1'b0;
    out_val  = rank_val;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = in_range ? StMod : StByp;
        end
      end
      StMod: begin
        state_d = StScan;
      end
      StScan: begin
        if (found && slot_free) begin
          scan_ack = 1'b1;
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      StByp: begin
        out_val = sample_q;
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        row_vld_q[ch_q] <= 1'b1;
        pos_q[ch_q]     <= (pos_q[ch_q] == PosW'(WINDOW - 1)) ? '0 : pos_q[ch_q] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q     <= ch_idx;
      sample_q <= sample_i;
    end
    if (out_load) begin
      median_q <= out_val;
    end
  end

  // window store: one row per channel
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_row_q <= mem_q[ch_idx];
    end
    if (wr_en) begin
      mem_q[ch_q] <= new_row;
    end
  end

  mrm_rank_sel #(
    .WINDOW (WINDOW),
    .RANK   (RankEff)
  ) u_rank_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wr_en),
    .win_i   (new_row),
    .ack_i   (scan_ack),
    .found_o (found),
    .value_o (rank_val)
  );

  a_mod_to_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMod |=> state_q == StScan)
    else $error("row update not followed by rank scan");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMod |-> int'(pos_q[ch_q]) < WINDOW)
    else $error("write position out of window");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StScan || $past(state_q) == StByp))
    else $error("result loaded outside scan or bypass");

  a_scan_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan && !found |=> state_q == StScan)
    else $error("scan left without a selected entry");

endmodule

`default_nettype wire
